FILE: hdl/rcf_pkg.sv
// Package for the radio command framer: command, status and job types,
// frame constants and the mode code tables.
// No dependencies; imported by every module of the framer.
package rcf_pkg;

  localparam int unsigned FreqW      = 30;
  localparam int unsigned FifoDepth  = 4;
  localparam int unsigned FifoPtrW   = $clog2(FifoDepth);
  localparam int unsigned ConvSteps  = 9;
  localparam int unsigned Recip10Sh  = 35;
  localparam logic [31:0] Recip10    = 32'hCCCC_CCCD;
  localparam logic [15:0] TimeoutRst = 16'd100;

  localparam logic [7:0] OpSetFreq  = 8'h01;
  localparam logic [7:0] OpSetMode  = 8'h07;
  localparam logic [7:0] OpRead     = 8'h03;
  localparam logic [7:0] PttOffCode = 8'h88;
  localparam logic [7:0] PttOnCode  = 8'h08;
  localparam logic [7:0] PttCharOff = 8'h30;
  localparam logic [7:0] PttCharMax = 8'h33;
  localparam logic [3:0] NumModes   = 4'd10;
  localparam logic [3:0] ModeUnknown = 4'd10;
  localparam logic [2:0] ReplyFreqBytes = 3'd4;
  localparam logic [2:0] FrameLastIdx   = 3'd4;
  localparam logic [2:0] StatusIdx      = 3'd5;

  localparam logic KindTx     = 1'b0;
  localparam logic KindStatus = 1'b1;

  typedef enum logic [2:0] {
    CMD_TUNE,
    CMD_OPMODE,
    CMD_SET_PTT,
    CMD_READ,
    CMD_RX_BYTE,
    CMD_TICK
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK,
    ST_PARSE_ERR,
    ST_HW_TIMEOUT
  } status_e;

  typedef enum logic [2:0] {
    JK_SEND,
    JK_SEND_READ,
    JK_PARSE_ERR,
    JK_RX,
    JK_TICK
  } job_kind_e;

  typedef struct packed {
    job_kind_e       kind;
    logic [4:0][7:0] bytes;
  } job_t;

  function automatic logic [7:0] mode_code(input logic [3:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0:    c = 8'h00;
      4'd1:    c = 8'h01;
      4'd2:    c = 8'h02;
      4'd3:    c = 8'h03;
      4'd4:    c = 8'h82;
      4'd5:    c = 8'h06;
      4'd6:    c = 8'h88;
      4'd7:    c = 8'h04;
      4'd8:    c = 8'h0a;
      4'd9:    c = 8'h0c;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [3:0] mode_index(input logic [7:0] code);
    logic [3:0] m;
    case (code)
      8'h00:   m = 4'd0;
      8'h01:   m = 4'd1;
      8'h02:   m = 4'd2;
      8'h03:   m = 4'd3;
      8'h82:   m = 4'd4;
      8'h06:   m = 4'd5;
      8'h08:   m = 4'd5;
      8'h88:   m = 4'd6;
      8'h04:   m = 4'd7;
      8'h0a:   m = 4'd8;
      8'h0c:   m = 4'd9;
      default: m = ModeUnknown;
    endcase
    return m;
  endfunction

endpackage

FILE: hdl/rcf_front.sv
// Front end of the radio command framer: accepts input words, classifies them
// into jobs and converts set-frequency values to packed BCD. Uses rcf_pkg.
module rcf_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [2:0]                   cmd_i,
  input  logic [rcf_pkg::FreqW-1:0]    freq_hz_i,
  input  logic [3:0]                   mode_name_i,
  input  logic [7:0]                   ptt_char_i,
  input  logic [7:0]                   rx_byte_i,
  input  logic                         full_i,
  output logic                         push_o,
  output rcf_pkg::job_t                job_o
);
  import rcf_pkg::*;

  logic             busy_q, busy_d;
  logic [3:0]       step_q, step_d;
  logic [FreqW-1:0] val_q, val_d;
  logic [31:0]      bcd_q, bcd_d;
  logic [FreqW+31:0] prod;
  logic [FreqW-1:0] quo;
  logic [FreqW-1:0] rem;
  logic             accept;
  logic             conv_done;
  logic             dec_push;
  job_t             dec_job;
  job_t             conv_job;

  assign in_ready_o = !busy_q && !full_i;
  assign accept     = in_valid_i && in_ready_o;

  // divide by ten through the reciprocal, one digit per step
  assign prod      = (FreqW+32)'(val_q) * (FreqW+32)'(Recip10);
  assign quo       = FreqW'(prod >> Recip10Sh);
  assign rem       = val_q - ((quo << 3) + (quo << 1));
  assign conv_done = busy_q && (step_q == 4'(ConvSteps - 1));

  always_comb begin
    dec_push = 1'b0;
    dec_job  = job_t'('0);
    case (cmd_e'(cmd_i))
      CMD_OPMODE: begin
        dec_push = 1'b1;
        if (mode_name_i >= NumModes) begin
          dec_job.kind = JK_PARSE_ERR;
        end else begin
          dec_job.kind     = JK_SEND;
          dec_job.bytes[0] = mode_code(mode_name_i);
          dec_job.bytes[4] = OpSetMode;
        end
      end
      CMD_SET_PTT: begin
        dec_push = 1'b1;
        if (ptt_char_i < PttCharOff || ptt_char_i > PttCharMax) begin
          dec_job.kind = JK_PARSE_ERR;
        end else begin
          dec_job.kind     = JK_SEND;
          dec_job.bytes[4] = (ptt_char_i == PttCharOff) ? PttOffCode : PttOnCode;
        end
      end
      CMD_READ: begin
        dec_push         = 1'b1;
        dec_job.kind     = JK_SEND_READ;
        dec_job.bytes[4] = OpRead;
      end
      CMD_RX_BYTE: begin
        dec_push         = 1'b1;
        dec_job.kind     = JK_RX;
        dec_job.bytes[0] = rx_byte_i;
      end
      CMD_TICK: begin
        dec_push     = 1'b1;
        dec_job.kind = JK_TICK;
      end
      default: begin
        dec_push = 1'b0;
      end
    endcase
  end

  always_comb begin
    busy_d = busy_q;
    step_d = step_q;
    val_d  = val_q;
    bcd_d  = bcd_q;
    if (busy_q) begin
      val_d  = quo;
      bcd_d  = {rem[3:0], bcd_q[31:4]};
      step_d = step_q + 4'd1;
      if (conv_done) begin
        busy_d = 1'b0;
      end
    end else if (accept && cmd_e'(cmd_i) == CMD_TUNE) begin
      busy_d = 1'b1;
      step_d = '0;
      val_d  = freq_hz_i;
    end
  end

  always_comb begin
    conv_job          = job_t'('0);
    conv_job.kind     = JK_SEND;
    conv_job.bytes[0] = bcd_d[31:24];
    conv_job.bytes[1] = bcd_d[23:16];
    conv_job.bytes[2] = bcd_d[15:8];
    conv_job.bytes[3] = bcd_d[7:0];
    conv_job.bytes[4] = OpSetFreq;
  end

  assign push_o = conv_done || (accept && dec_push);
  assign job_o  = busy_q ? conv_job : dec_job;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
    bcd_q <= bcd_d;
  end

endmodule

FILE: hdl/rcf_fifo.sv
// Job queue between the front and back ends of the radio command framer.
// Small register queue of job_t words. Uses rcf_pkg.
module rcf_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  rcf_pkg::job_t data_i,
  input  logic          pop_i,
  output rcf_pkg::job_t data_o,
  output logic          empty_o,
  output logic          full_o
);
  import rcf_pkg::*;

  job_t                mem_q [FifoDepth];
  logic [FifoPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [FifoPtrW:0]   cnt_q;
  logic                do_push, do_pop;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == (FifoPtrW+1)'(FifoDepth));
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

FILE: hdl/rcf_back.sv
// Back end of the radio command framer: carries out queued jobs, tracks the
// read reply and timeout, and drives the registered result word. Uses rcf_pkg.
module rcf_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  rcf_pkg::job_t             job_i,
  input  logic                      empty_i,
  output logic                      pop_o,
  input  logic [15:0]               timeout_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic                      result_kind_o,
  output logic [7:0]                tx_byte_o,
  output logic                      last_o,
  output logic [1:0]                status_o,
  output logic [rcf_pkg::FreqW-1:0] freq_out_o,
  output logic [3:0]                mode_out_o
);
  import rcf_pkg::*;

  logic             out_valid_q, out_valid_d;
  logic             kind_q, kind_d;
  logic [7:0]       tx_q, tx_d;
  logic             last_q, last_d;
  logic [1:0]       status_q, status_d;
  logic [FreqW-1:0] freq_q, freq_d;
  logic [3:0]       mode_q, mode_d;
  logic [2:0]       idx_q, idx_d;
  logic             awaiting_q, awaiting_d;
  logic [2:0]       count_q, count_d;
  logic [FreqW-1:0] accum_q, accum_d;
  logic [15:0]      wait_q, wait_d;
  logic             step;
  logic             emit;
  logic [FreqW-1:0] digit_sum;
  logic [FreqW-1:0] sum_x100;
  logic [15:0]      wait_inc;

  assign step      = !empty_i && (!out_valid_q || out_ready_i);
  assign digit_sum = accum_q + FreqW'(job_i.bytes[0][7:4]) * FreqW'(100)
                     + FreqW'(job_i.bytes[0][3:0]) * FreqW'(10);
  assign sum_x100  = (digit_sum << 6) + (digit_sum << 5) + (digit_sum << 2);
  assign wait_inc  = wait_q + 16'd1;

  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    kind_d      = KindStatus;
    tx_d        = '0;
    last_d      = 1'b0;
    status_d    = ST_OK;
    freq_d      = '0;
    mode_d      = '0;
    idx_d       = idx_q;
    awaiting_d  = awaiting_q;
    count_d     = count_q;
    accum_d     = accum_q;
    wait_d      = wait_q;
    emit        = 1'b0;
    pop_o       = 1'b0;
    if (step) begin
      case (job_i.kind)
        JK_SEND: begin
          emit       = 1'b1;
          awaiting_d = 1'b0;
          if (idx_q == StatusIdx) begin
            last_d = 1'b1;
            pop_o  = 1'b1;
            idx_d  = '0;
          end else begin
            kind_d = KindTx;
            tx_d   = job_i.bytes[idx_q];
            idx_d  = idx_q + 3'd1;
          end
        end
        JK_SEND_READ: begin
          emit   = 1'b1;
          kind_d = KindTx;
          tx_d   = job_i.bytes[idx_q];
          if (idx_q == FrameLastIdx) begin
            last_d     = 1'b1;
            pop_o      = 1'b1;
            idx_d      = '0;
            awaiting_d = 1'b1;
            count_d    = '0;
            accum_d    = '0;
            wait_d     = '0;
          end else begin
            awaiting_d = 1'b0;
            idx_d      = idx_q + 3'd1;
          end
        end
        JK_PARSE_ERR: begin
          emit       = 1'b1;
          last_d     = 1'b1;
          status_d   = ST_PARSE_ERR;
          pop_o      = 1'b1;
          awaiting_d = 1'b0;
        end
        JK_RX: begin
          pop_o = 1'b1;
          if (awaiting_q) begin
            wait_d = '0;
            if (count_q < ReplyFreqBytes) begin
              accum_d = (count_q < ReplyFreqBytes - 3'd1) ? sum_x100 : digit_sum;
              count_d = count_q + 3'd1;
            end else begin
              emit       = 1'b1;
              last_d     = 1'b1;
              freq_d     = accum_q;
              mode_d     = mode_index(job_i.bytes[0]);
              awaiting_d = 1'b0;
              count_d    = '0;
            end
          end
        end
        JK_TICK: begin
          pop_o = 1'b1;
          if (awaiting_q) begin
            if (wait_inc >= timeout_i || wait_inc == '0) begin
              emit       = 1'b1;
              last_d     = 1'b1;
              status_d   = ST_HW_TIMEOUT;
              awaiting_d = 1'b0;
              count_d    = '0;
              wait_d     = '0;
            end else begin
              wait_d = wait_inc;
            end
          end
        end
        default: begin
          pop_o = 1'b1;
        end
      endcase
    end
    if (emit) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      idx_q       <= '0;
      awaiting_q  <= 1'b0;
      count_q     <= '0;
      accum_q     <= '0;
      wait_q      <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      idx_q       <= idx_d;
      awaiting_q  <= awaiting_d;
      count_q     <= count_d;
      accum_q     <= accum_d;
      wait_q      <= wait_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      kind_q   <= kind_d;
      tx_q     <= tx_d;
      last_q   <= last_d;
      status_q <= status_d;
      freq_q   <= freq_d;
      mode_q   <= mode_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign result_kind_o = kind_q;
  assign tx_byte_o     = tx_q;
  assign last_o        = last_q;
  assign status_o      = status_q;
  assign freq_out_o    = freq_q;
  assign mode_out_o    = mode_q;

endmodule

FILE: hdl/radio_cat_command_framer_unit.sv
// Radio command framer, top level: front end, job queue, back end and the
// timeout register. Depends on rcf_pkg, rcf_front, rcf_fifo and rcf_back.
//
// Turns host commands into five-byte radio frames and reports status, and
// gathers the five reply bytes of a read into a frequency and mode index.
// Set mode, PTT, read, received-byte and tick words are decoded combinationally
// and queued as jobs; a set-frequency word occupies the front end while its
// BCD digits come out of the divide-by-ten step, one digit per cycle. The back
// end gives at most one result word per cycle, while the queue holds a job and
// the output is not stalled; a frame with status gives six words, and the front
// end runs ahead while results wait on the output register.
module radio_cat_command_framer_unit (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [15:0]               cfg_wdata_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [2:0]                cmd_i,
  input  logic [rcf_pkg::FreqW-1:0] freq_hz_i,
  input  logic [3:0]                mode_name_i,
  input  logic [7:0]                ptt_char_i,
  input  logic [7:0]                rx_byte_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic                      result_kind_o,
  output logic [7:0]                tx_byte_o,
  output logic                      last_o,
  output logic [1:0]                status_o,
  output logic [rcf_pkg::FreqW-1:0] freq_out_o,
  output logic [3:0]                mode_out_o
);
  import rcf_pkg::*;

  logic [15:0] timeout_q;
  logic        push;
  logic        pop;
  logic        empty;
  logic        full;
  job_t        push_job;
  job_t        head_job;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= TimeoutRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      timeout_q <= cfg_wdata_i;
    end
  end

  rcf_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .cmd_i       (cmd_i),
    .freq_hz_i   (freq_hz_i),
    .mode_name_i (mode_name_i),
    .ptt_char_i  (ptt_char_i),
    .rx_byte_i   (rx_byte_i),
    .full_i      (full),
    .push_o      (push),
    .job_o       (push_job)
  );

  rcf_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_job),
    .pop_i   (pop),
    .data_o  (head_job),
    .empty_o (empty),
    .full_o  (full)
  );

  rcf_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .job_i         (head_job),
    .empty_i       (empty),
    .pop_o         (pop),
    .timeout_i     (timeout_q),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .result_kind_o (result_kind_o),
    .tx_byte_o     (tx_byte_o),
    .last_o        (last_o),
    .status_o      (status_o),
    .freq_out_o    (freq_out_o),
    .mode_out_o    (mode_out_o)
  );

endmodule

FILE: hdl/rcf_checker.sv
// Port checker for the radio command framer, bound to the top level.
// Sees the top-level ports only. Uses rcf_pkg.
module rcf_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      out_valid_o,
  input logic                      out_ready_i,
  input logic                      result_kind_o,
  input logic [7:0]                tx_byte_o,
  input logic                      last_o,
  input logic [1:0]                status_o,
  input logic [rcf_pkg::FreqW-1:0] freq_out_o,
  input logic [3:0]                mode_out_o
);
  import rcf_pkg::*;

  // hold a stalled result word
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(tx_byte_o) && $stable(last_o))
    else $error("result word changed while stalled");

  a_tx_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && result_kind_o == KindTx |->
      status_o == ST_OK && freq_out_o == '0 && mode_out_o == '0)
    else $error("transmit word carries status fields");

  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && result_kind_o == KindStatus |-> last_o && tx_byte_o == '0)
    else $error("status word not last or carries a byte");

  a_err_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_OK |->
      result_kind_o == KindStatus && freq_out_o == '0 && mode_out_o == '0)
    else $error("error report carries read-back data");

  a_mode_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> mode_out_o <= ModeUnknown && status_o != 2'd3)
    else $error("mode or status out of range");

endmodule

bind radio_cat_command_framer_unit rcf_checker u_rcf_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .result_kind_o (result_kind_o),
  .tx_byte_o     (tx_byte_o),
  .last_o        (last_o),
  .status_o      (status_o),
  .freq_out_o    (freq_out_o),
  .mode_out_o    (mode_out_o)
);

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for the radio command framer: drives command words, predicts every
// transmit byte and status report, and checks the result words against that prediction.
// Depends on rcf_pkg and radio_cat_command_framer_unit.
module tb_top;
  import rcf_pkg::*;

  localparam logic [2:0]  CmdSpare6  = 3'd6;
  localparam logic [2:0]  CmdSpare7  = 3'd7;
  localparam logic [7:0]  WfmAltCode = 8'h08;
  localparam logic [3:0]  ModeWfm    = 4'd5;
  localparam int unsigned HoldOff    = 40;
  localparam int unsigned StallLimit = 5000;
  localparam int unsigned MaxFreqHz  = 999999999;
  localparam logic [9:0][7:0] ModeCodes = {8'h0c, 8'h0a, 8'h04, 8'h88, 8'h06,
                                           8'h82, 8'h03, 8'h02, 8'h01, 8'h00};

  typedef struct packed {
    logic [2:0]       cmd;
    logic [FreqW-1:0] freq;
    logic [3:0]       mode;
    logic [7:0]       ptt;
    logic [7:0]       rx;
  } cmd_word_t;

  typedef struct packed {
    logic             kind;
    logic [7:0]       tx;
    logic             last;
    logic [1:0]       status;
    logic [FreqW-1:0] freq;
    logic [3:0]       mode;
  } result_word_t;

  logic        clk_i;
  logic        rst_ni    = 1'b0;
  logic        cfg_valid = 1'b0;
  logic [15:0] cfg_wdata = 16'h0000;
  logic        in_valid  = 1'b0;
  logic        out_ready = 1'b0;
  cmd_word_t   cur_word  = '0;
  logic        cfg_ready_o, in_ready_o, out_valid_o;
  logic        result_kind_o, last_o;
  logic [7:0]  tx_byte_o;
  logic [1:0]  status_o;
  logic [FreqW-1:0] freq_out_o;
  logic [3:0]  mode_out_o;

  cmd_word_t    host_words[$];
  result_word_t owed_words[$];

  int unsigned idle_pct    = 0;
  int unsigned stall_pct   = 0;
  int unsigned errors      = 0;
  int unsigned quiet_count = 0;
  int unsigned gen_limit   = TimeoutRst;

  logic             reading    = 1'b0;
  logic [2:0]       reply_idx  = '0;
  logic [FreqW-1:0] freq_sum   = '0;
  logic [15:0]      tick_count = '0;
  logic [15:0]      tick_limit = TimeoutRst;

  radio_cat_command_framer_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_wdata_i   (cfg_wdata),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready_o),
    .cmd_i         (cur_word.cmd),
    .freq_hz_i     (cur_word.freq),
    .mode_name_i   (cur_word.mode),
    .ptt_char_i    (cur_word.ptt),
    .rx_byte_i     (cur_word.rx),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready),
    .result_kind_o (result_kind_o),
    .tx_byte_o     (tx_byte_o),
    .last_o        (last_o),
    .status_o      (status_o),
    .freq_out_o    (freq_out_o),
    .mode_out_o    (mode_out_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic void owe(input logic kind, input logic [7:0] tx, input logic last,
                              input status_e st, input logic [FreqW-1:0] f,
                              input logic [3:0] m);
    owed_words.push_back({kind, tx, last, st, f, m});
  endfunction

  function automatic void owe_frame(input logic [4:0][7:0] fb, input logic with_status);
    int i;
    for (i = 0; i < 5; i++) begin
      owe(KindTx, fb[i], !with_status && i == FrameLastIdx, ST_OK, '0, '0);
    end
    if (with_status) begin
      owe(KindStatus, 8'h00, 1'b1, ST_OK, '0, '0);
    end
  endfunction

  function automatic logic [3:0] mode_from_code(input logic [7:0] code);
    logic [3:0] m;
    int i;
    m = ModeUnknown;
    if (code == WfmAltCode) m = ModeWfm;
    for (i = 0; i < NumModes; i++) begin
      if (ModeCodes[i] == code) m = i[3:0];
    end
    return m;
  endfunction

  function automatic void frame_command(input cmd_word_t w);
    logic [4:0][7:0] fb;
    logic [31:0]     v, f;
    logic [3:0]      dig [8];
    int              i;
    fb = '0;
    if (w.cmd <= CMD_READ) reading = 1'b0;
    case (w.cmd)
      CMD_TUNE: begin
        v = w.freq / 10;
        for (i = 0; i < 8; i++) begin
          dig[i] = 4'(v % 10);
          v = v / 10;
        end
        for (i = 0; i < 4; i++) fb[i] = {dig[7 - 2 * i], dig[6 - 2 * i]};
        fb[4] = OpSetFreq;
        owe_frame(fb, 1'b1);
      end
      CMD_OPMODE: begin
        if (w.mode >= NumModes) begin
          owe(KindStatus, 8'h00, 1'b1, ST_PARSE_ERR, '0, '0);
        end else begin
          fb[0] = ModeCodes[w.mode];
          fb[4] = OpSetMode;
          owe_frame(fb, 1'b1);
        end
      end
      CMD_SET_PTT: begin
        if (w.ptt < PttCharOff || w.ptt > PttCharMax) begin
          owe(KindStatus, 8'h00, 1'b1, ST_PARSE_ERR, '0, '0);
        end else begin
          fb[4] = (w.ptt == PttCharOff) ? PttOffCode : PttOnCode;
          owe_frame(fb, 1'b1);
        end
      end
      CMD_READ: begin
        fb[4] = OpRead;
        reading = 1'b1;
        reply_idx = '0;
        freq_sum = '0;
        tick_count = '0;
        owe_frame(fb, 1'b0);
      end
      CMD_RX_BYTE: begin
        if (reading) begin
          tick_count = '0;
          if (reply_idx < ReplyFreqBytes) begin
            f = freq_sum + w.rx[7:4] * 100 + w.rx[3:0] * 10;
            if (reply_idx < ReplyFreqBytes - 1) f = f * 100;
            freq_sum = f[FreqW-1:0];
            reply_idx = reply_idx + 3'd1;
          end else begin
            reading = 1'b0;
            reply_idx = '0;
            owe(KindStatus, 8'h00, 1'b1, ST_OK, freq_sum, mode_from_code(w.rx));
          end
        end
      end
      CMD_TICK: begin
        if (reading) begin
          tick_count = tick_count + 16'd1;
          if (tick_count >= tick_limit || tick_count == 0) begin
            reading = 1'b0;
            reply_idx = '0;
            tick_count = '0;
            owe(KindStatus, 8'h00, 1'b1, ST_HW_TIMEOUT, '0, '0);
          end
        end
      end
      default: ;
    endcase
  endfunction

  // sender and receiver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid  <= 1'b0;
      out_ready <= 1'b0;
    end else begin
      if (!in_valid || in_ready_o) begin
        if (host_words.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
          cur_word <= host_words.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  always @(posedge clk_i) begin
    result_word_t got, want;
    if (rst_ni) begin
      if (cfg_valid && cfg_ready_o) tick_limit = cfg_wdata;
      if (in_valid && in_ready_o) frame_command(cur_word);
      if (out_valid_o && out_ready) begin
        got = {result_kind_o, tx_byte_o, last_o, status_o, freq_out_o, mode_out_o};
        if (owed_words.size() == 0) begin
          $display("%0t: unexpected word kind %0d byte %02h last %0d status %0d freq %0d mode %0d",
                   $time, got.kind, got.tx, got.last, got.status, got.freq, got.mode);
          errors++;
        end else begin
          want = owed_words.pop_front();
          if (got !== want) begin
            $display("%0t: expected kind %0d byte %02h last %0d status %0d freq %0d mode %0d",
                     $time, want.kind, want.tx, want.last, want.status, want.freq, want.mode);
            $display("%0t: actual   kind %0d byte %02h last %0d status %0d freq %0d mode %0d",
                     $time, got.kind, got.tx, got.last, got.status, got.freq, got.mode);
            errors++;
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && in_ready_o) || (out_valid_o && out_ready) ||
          (cfg_valid && cfg_ready_o)) begin
        quiet_count <= 0;
      end else if (quiet_count >= StallLimit) begin
        $display("Regression FAIL");
        $finish;
      end else begin
        quiet_count <= quiet_count + 1;
      end
    end
  end

  task automatic send(input logic [2:0] cmd, input logic [31:0] val);
    cmd_word_t w;
    w.cmd  = cmd;
    w.freq = FreqW'($urandom());
    w.mode = 4'($urandom());
    w.ptt  = 8'($urandom());
    w.rx   = 8'($urandom());
    case (cmd)
      CMD_TUNE:    w.freq = val[FreqW-1:0];
      CMD_OPMODE:  w.mode = val[3:0];
      CMD_SET_PTT: w.ptt  = val[7:0];
      CMD_RX_BYTE: w.rx   = val[7:0];
      default: ;
    endcase
    host_words.push_back(w);
  endtask

  task automatic send_ticks(input int unsigned n);
    repeat (n) send(CMD_TICK, 0);
  endtask

  function automatic logic [7:0] bcd_byte();
    int unsigned r;
    r = $urandom_range(0, 99);
    return {r[3:0] % 10 == r % 10 ? 4'(r / 10) : 4'(r / 10), 4'(r % 10)};
  endfunction

  task automatic gen_traffic(input int unsigned n);
    int unsigned cnt, pick, k, gaps, lim, len;
    cnt = 0;
    lim = (gen_limit == 0) ? 1 : gen_limit;
    while (cnt < n) begin
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        send(CMD_READ, 0);
        cnt += 6;
        for (k = 0; k < 5; k++) begin
          gaps = (lim > 1) ? $urandom_range(0, (lim - 1 < 3) ? lim - 1 : 3) : 0;
          send_ticks(gaps);
          cnt += gaps;
          if (k < 4) begin
            send(CMD_RX_BYTE, ($urandom_range(0, 9) < 7) ? bcd_byte() : $urandom_range(0, 255));
          end else if ($urandom_range(0, 9) < 7) begin
            send(CMD_RX_BYTE, ($urandom_range(0, 10) == 10) ? WfmAltCode
                                                            : ModeCodes[$urandom_range(0, 9)]);
          end else begin
            send(CMD_RX_BYTE, $urandom_range(0, 255));
          end
        end
      end else if (pick < 40) begin
        len = (lim <= 120) ? $urandom_range(lim - 1, lim + 1) : $urandom_range(1, 20);
        send(CMD_READ, 0);
        send_ticks(len);
        cnt += 1 + len;
      end else if (pick < 50) begin
        send(CMD_READ, 0);
        len = $urandom_range(0, 4);
        repeat (len) send(CMD_RX_BYTE, $urandom_range(0, 255));
        send(3'($urandom_range(CMD_TUNE, CMD_READ)), $urandom());
        cnt += 2 + len;
      end else if (pick < 65) begin
        send(CMD_TUNE, ($urandom_range(0, 9) == 0) ? $urandom()
                                                   : $urandom_range(0, MaxFreqHz));
        cnt++;
      end else if (pick < 75) begin
        send(CMD_OPMODE, ($urandom_range(0, 3) != 0) ? $urandom_range(0, 9)
                                                     : $urandom_range(0, 15));
        cnt++;
      end else if (pick < 88) begin
        send(CMD_SET_PTT, ($urandom_range(0, 9) < 7) ? $urandom_range(PttCharOff, PttCharMax)
                                                     : $urandom_range(0, 255));
        cnt++;
      end else begin
        case ($urandom_range(0, 3))
          0: send(CMD_RX_BYTE, $urandom_range(0, 255));
          1: send(CMD_TICK, 0);
          2: send(CmdSpare6, 0);
          default: send(CmdSpare7, 0);
        endcase
        cnt++;
      end
    end
  endtask

  // drain both sides, then hold off while the block finishes silent words
  task automatic settle();
    while (host_words.size() != 0 || in_valid) @(posedge clk_i);
    while (owed_words.size() != 0) @(posedge clk_i);
    repeat (HoldOff) @(posedge clk_i);
  endtask

  task automatic run_phase(input logic [15:0] limit, input int unsigned idle,
                           input int unsigned stall, input int unsigned n);
    settle();
    cfg_valid <= 1'b1;
    cfg_wdata <= limit;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid <= 1'b0;
    gen_limit = limit;
    idle_pct  = idle;
    stall_pct = stall;
    gen_traffic(n);
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    send(CMD_TUNE, 0);
    send(CMD_TUNE, MaxFreqHz);
    send(CMD_TUNE, 32'h3FFF_FFFF);
    send(CMD_TUNE, 145678901);
    send(CMD_OPMODE, 0);
    send(CMD_OPMODE, 9);
    send(CMD_OPMODE, 4);
    send(CMD_OPMODE, NumModes);
    send(CMD_OPMODE, 15);
    send(CMD_SET_PTT, PttCharOff);
    send(CMD_SET_PTT, PttCharMax);
    send(CMD_SET_PTT, PttCharOff - 1);
    send(CMD_SET_PTT, PttCharMax + 1);
    send(CMD_SET_PTT, 8'hFF);
    send(CMD_RX_BYTE, 8'hAA);
    send(CMD_TICK, 0);
    send(CmdSpare6, 0);
    send(CmdSpare7, 0);
    send(CMD_READ, 0);
    send(CMD_RX_BYTE, 8'h14);
    send(CMD_RX_BYTE, 8'h52);
    send(CMD_RX_BYTE, 8'hFA);
    send(CMD_RX_BYTE, 8'h00);
    send(CMD_RX_BYTE, WfmAltCode);
    send(CMD_READ, 0);
    send(CMD_RX_BYTE, 8'hFF);
    send(CMD_TUNE, 7074000);
    gen_traffic(33);

    run_phase(16'd1, 63, 0, 80);
    run_phase(16'd0, 0, 63, 60);
    run_phase(16'd3, 28, 28, 80);
    run_phase(16'hFFFF, 0, 0, 50);
    run_phase(16'd7, 28, 28, 50);
    settle();

    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
